@@ rtl/path_lifecycle_fsm_assert.svh @@
// Assertion macros used by the checker file
`ifndef PATH_LIFECYCLE_FSM_ASSERT_SVH
`define PATH_LIFECYCLE_FSM_ASSERT_SVH

// Check that an implication holds at every clock edge outside reset
`define PLF_ASSERT_IMPL(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// Check that an expression holds in the cycle after a trigger
`define PLF_ASSERT_NEXT(label, clk, rstn, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (trig) |=> (cond)) \
        else $error(msg);

`endif

@@ rtl/plf_pkg.sv @@
// ----------------------------------------------------------------------------
// plf_pkg
// Types, codes and reset constants for the path lifecycle controller.
// ----------------------------------------------------------------------------
package plf_pkg;

    localparam int unsigned IN_W  = 136;
    localparam int unsigned OUT_W = 96;

    typedef enum logic [3:0] {
        ST_PENDING     = 4'd0,
        ST_CREATE_WAIT = 4'd1,
        ST_VALIDATING  = 4'd2,
        ST_ACTIVE      = 4'd3,
        ST_STANDBY     = 4'd4,
        ST_DEGRADED    = 4'd5,
        ST_CLOSED_REC  = 4'd6,
        ST_CLOSED_DROP = 4'd7,
        ST_CLOSED_FREE = 4'd8
    } life_state_t;

    typedef enum logic [3:0] {
        OP_ACTIVATE   = 4'd0,
        OP_RETRY      = 4'd1,
        OP_VALIDATED  = 4'd2,
        OP_XREMOVED   = 4'd3,
        OP_REACTIVATE = 4'd4,
        OP_DROP       = 4'd5,
        OP_REMOVE     = 4'd6,
        OP_ATTACH     = 4'd7,
        OP_CONN_RESET = 4'd8,
        OP_SOCK_CLOSE = 4'd9,
        OP_STABLE     = 4'd10
    } opcode_t;

    localparam logic [1:0] RES_OK   = 2'd0;
    localparam logic [1:0] RES_TRAN = 2'd1;
    localparam logic [1:0] RES_PERM = 2'd2;
    localparam logic [1:0] RES_BAD  = 2'd3;

    localparam logic [3:0] WHY_ATTACH   = 4'd0;
    localparam logic [3:0] WHY_ACT_OK   = 4'd1;
    localparam logic [3:0] WHY_ACT_FAIL = 4'd2;
    localparam logic [3:0] WHY_XREMOVED = 4'd3;
    localparam logic [3:0] WHY_DROPPED  = 4'd4;
    localparam logic [3:0] WHY_REMOVE   = 4'd5;
    localparam logic [3:0] WHY_REACT    = 4'd6;
    localparam logic [3:0] WHY_RESET    = 4'd7;
    localparam logic [3:0] WHY_BUDGET   = 4'd8;
    localparam logic [3:0] WHY_SOCK     = 4'd9;

    localparam logic [2:0] PUB_PENDING  = 3'd0;
    localparam logic [2:0] PUB_ACTIVE   = 3'd1;
    localparam logic [2:0] PUB_STANDBY  = 3'd2;
    localparam logic [2:0] PUB_DEGRADED = 3'd3;
    localparam logic [2:0] PUB_CLOSED   = 3'd4;

    localparam logic [1:0] PEER_NONE      = 2'd0;
    localparam logic [1:0] PEER_STANDBY   = 2'd1;
    localparam logic [1:0] PEER_AVAILABLE = 2'd2;
    localparam logic [1:0] PEER_FROZEN    = 2'd3;

    localparam logic [2:0] REG_BASE   = 3'd0;
    localparam logic [2:0] REG_MAX    = 3'd1;
    localparam logic [2:0] REG_TRIES  = 3'd2;
    localparam logic [2:0] REG_STABLE = 3'd3;
    localparam logic [2:0] REG_PWARN  = 3'd4;
    localparam logic [2:0] REG_DGRACE = 3'd5;

    localparam logic [31:0] RST_BASE   = 32'd1000000;
    localparam logic [31:0] RST_MAX    = 32'd30000000;
    localparam logic [7:0]  RST_TRIES  = 8'd5;
    localparam logic [31:0] RST_STABLE = 32'd30000000;
    localparam logic [31:0] RST_PWARN  = 32'd10000000;
    localparam logic [31:0] RST_DGRACE = 32'd10000000;

    typedef struct packed {
        logic [31:0] base_delay;
        logic [31:0] max_delay;
        logic [7:0]  max_retries;
        logic [31:0] stable_thr;
        logic [31:0] pend_warn;
        logic [31:0] deg_grace;
    } cfg_t;

    typedef struct packed {
        logic [3:0]  opcode;
        logic [1:0]  res;
        logic [61:0] path_id;
        logic [63:0] now;
        logic        to_standby;
    } item_t;

    typedef struct packed {
        life_state_t state;
        logic        sock_valid;
        logic        attached;
        logic        live;
        logic [61:0] path_id;
        logic [7:0]  fails;
        logic [63:0] due;
        logic [63:0] stable_since;
        logic [63:0] entered;
    } ctx_t;

    typedef struct packed {
        logic [3:0]  lstate;
        logic [2:0]  pub;
        logic        changed;
        logic [3:0]  reason;
        logic        raise;
        logic [1:0]  peer;
        logic        unexpected;
        logic [7:0]  retries;
        logic [63:0] deadline;
        logic        warn;
        logic        budget;
    } result_t;

    function automatic logic [2:0] public_of(input life_state_t s);
        logic [2:0] p;
        case (s)
            ST_PENDING, ST_CREATE_WAIT, ST_VALIDATING: p = PUB_PENDING;
            ST_ACTIVE:   p = PUB_ACTIVE;
            ST_STANDBY:  p = PUB_STANDBY;
            ST_DEGRADED: p = PUB_DEGRADED;
            default:     p = PUB_CLOSED;
        endcase
        return p;
    endfunction

endpackage

@@ rtl/plf_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// plf_cfg_regs
// Configuration register file with write-only access.
// ----------------------------------------------------------------------------
module plf_cfg_regs (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_we,
    input  logic [2:0]    cfg_addr,
    input  logic [31:0]   cfg_wdata,
    output plf_pkg::cfg_t cfg
);
    import plf_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{RST_BASE, RST_MAX, RST_TRIES, RST_STABLE, RST_PWARN, RST_DGRACE};
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_BASE:   cfg_reg.base_delay  <= cfg_wdata;
                REG_MAX:    cfg_reg.max_delay   <= cfg_wdata;
                REG_TRIES:  cfg_reg.max_retries <= cfg_wdata[7:0];
                REG_STABLE: cfg_reg.stable_thr  <= cfg_wdata;
                REG_PWARN:  cfg_reg.pend_warn   <= cfg_wdata;
                REG_DGRACE: cfg_reg.deg_grace   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/plf_backoff.sv @@
// ----------------------------------------------------------------------------
// plf_backoff
// Backoff delay: base shifted by retries-1, clamped to the maximum.
// ----------------------------------------------------------------------------
module plf_backoff (
    input  logic [31:0] base_delay,
    input  logic [31:0] max_delay,
    input  logic [7:0]  retries,
    output logic [31:0] delay
);
    // Doubling stops once at or above max, so result is min(base<<(r-1), max).
    logic [7:0]  shamt;
    logic [63:0] wide;
    logic        over;

    always_comb begin
        shamt = (retries == 8'd0) ? 8'd0 : retries - 8'd1;
        over  = 1'b0;
        wide  = {32'd0, base_delay};
        if (shamt >= 8'd32) begin
            over = (base_delay != 32'd0);
        end else begin
            wide = {32'd0, base_delay} << shamt[4:0];
        end
        if (over || wide > {32'd0, max_delay}) begin
            delay = max_delay;
        end else begin
            delay = wide[31:0];
        end
    end

endmodule

@@ rtl/plf_next_state.sv @@
// ----------------------------------------------------------------------------
// plf_next_state
// Event decode: next lifecycle context and the result fields.
// ----------------------------------------------------------------------------
module plf_next_state (
    input  plf_pkg::cfg_t    cfg,
    input  plf_pkg::item_t   item,
    input  plf_pkg::ctx_t    ctx,
    output plf_pkg::ctx_t    ctx_next,
    output plf_pkg::result_t res
);
    import plf_pkg::*;

    logic [7:0]  fails_inc;
    logic [31:0] delay;
    logic        go;
    life_state_t target;
    logic [3:0]  why;
    logic        unexp;
    logic        budget;
    logic        fail_path;
    life_state_t fail_tgt;
    logic        free_chk;
    logic [1:0]  peer;
    logic        changed;
    logic [63:0] since;
    logic        warn;
    logic        sock_n;
    logic        live_n;
    logic [61:0] pid_n;

    assign fails_inc = (ctx.fails == 8'hFF) ? 8'hFF : ctx.fails + 8'd1;

    plf_backoff u_backoff (
        .base_delay (cfg.base_delay),
        .max_delay  (cfg.max_delay),
        .retries    (fails_inc),
        .delay      (delay)
    );

    always_comb begin
        ctx_next  = ctx;
        go        = 1'b0;
        target    = ctx.state;
        why       = WHY_ATTACH;
        unexp     = 1'b0;
        budget    = 1'b0;
        fail_path = 1'b0;
        fail_tgt  = ST_CREATE_WAIT;
        free_chk  = 1'b0;
        sock_n    = ctx.sock_valid;
        live_n    = ctx.live;
        pid_n     = ctx.path_id;

        case (item.opcode)
            OP_ACTIVATE, OP_RETRY: begin
                if ((item.opcode == OP_ACTIVATE && ctx.state != ST_PENDING) ||
                    (item.opcode == OP_RETRY && ctx.state != ST_CREATE_WAIT &&
                     ctx.state != ST_DEGRADED)) begin
                    unexp = 1'b1;
                end else begin
                    fail_tgt = (item.opcode == OP_ACTIVATE) ? ST_CREATE_WAIT : ctx.state;
                    case (item.res)
                        RES_OK: begin
                            ctx_next.path_id = item.path_id;
                            ctx_next.live    = 1'b1;
                            ctx_next.due     = 64'd0;
                            go = 1'b1; target = ST_VALIDATING; why = WHY_ACT_OK;
                        end
                        RES_TRAN: begin
                            fail_path = 1'b1; why = WHY_ACT_FAIL;
                        end
                        RES_PERM: begin
                            ctx_next.live = 1'b0; ctx_next.path_id = '0;
                            ctx_next.stable_since = 64'd0; ctx_next.due = 64'd0;
                            go = 1'b1; target = ST_CLOSED_REC; why = WHY_ACT_FAIL;
                        end
                        default: unexp = 1'b1;
                    endcase
                end
            end
            OP_VALIDATED: begin
                if (ctx.state != ST_VALIDATING) begin
                    unexp = 1'b1;
                end else begin
                    ctx_next.stable_since = item.now;
                    go = 1'b1; why = WHY_ACT_OK;
                    target = item.to_standby ? ST_STANDBY : ST_ACTIVE;
                end
            end
            OP_XREMOVED: begin
                why = WHY_XREMOVED;
                if (ctx.state == ST_VALIDATING) begin
                    fail_path = 1'b1; fail_tgt = ST_CREATE_WAIT;
                end else if (ctx.state == ST_ACTIVE || ctx.state == ST_STANDBY) begin
                    fail_path = 1'b1; fail_tgt = ST_DEGRADED;
                end else if (ctx.state == ST_CLOSED_DROP) begin
                    ctx_next.live = 1'b0; ctx_next.path_id = '0;
                    live_n = 1'b0; pid_n = '0; free_chk = 1'b1;
                end else begin
                    unexp = 1'b1;
                end
            end
            OP_REACTIVATE: begin
                if (ctx.state != ST_CLOSED_REC && ctx.state != ST_CREATE_WAIT &&
                    ctx.state != ST_DEGRADED) begin
                    unexp = 1'b1;
                end else if (item.res == RES_OK) begin
                    ctx_next.path_id = item.path_id;
                    ctx_next.live    = 1'b1;
                    ctx_next.due     = 64'd0;
                    go = 1'b1; target = ST_VALIDATING; why = WHY_REACT;
                end else if (item.res == RES_BAD) begin
                    unexp = 1'b1;
                end
            end
            OP_DROP, OP_REMOVE: begin
                if (ctx.state != ST_CLOSED_DROP && ctx.state != ST_CLOSED_FREE) begin
                    ctx_next.attached = 1'b0;
                    ctx_next.due = 64'd0; ctx_next.stable_since = 64'd0;
                    go = 1'b1; target = ST_CLOSED_DROP;
                    why = (item.opcode == OP_DROP) ? WHY_DROPPED : WHY_REMOVE;
                end
            end
            OP_ATTACH: begin
                if (ctx.state != ST_CLOSED_FREE) begin
                    unexp = 1'b1;
                end else begin
                    ctx_next.sock_valid = 1'b1; ctx_next.attached = 1'b1;
                    go = 1'b1; target = ST_PENDING; why = WHY_ATTACH;
                end
            end
            OP_CONN_RESET: begin
                ctx_next.live = 1'b0; ctx_next.path_id = '0; ctx_next.due = 64'd0;
                ctx_next.fails = 8'd0; ctx_next.stable_since = 64'd0;
                live_n = 1'b0; pid_n = '0;
                why = WHY_RESET;
                if (ctx.attached) begin
                    go = 1'b1; target = ST_PENDING;
                end else begin
                    free_chk = 1'b1;
                end
            end
            OP_SOCK_CLOSE: begin
                if (ctx.state != ST_CLOSED_DROP) begin
                    unexp = 1'b1;
                end else begin
                    ctx_next.sock_valid = 1'b0; sock_n = 1'b0;
                    free_chk = 1'b1; why = WHY_SOCK;
                end
            end
            OP_STABLE: begin
                if ((ctx.state == ST_ACTIVE || ctx.state == ST_STANDBY) &&
                    ctx.stable_since != 64'd0 && ctx.live &&
                    (item.now - ctx.stable_since) >= {32'd0, cfg.stable_thr}) begin
                    ctx_next.fails = 8'd0;
                    ctx_next.stable_since = item.now;
                    budget = 1'b1;
                end
            end
            default: unexp = 1'b1;
        endcase

        if (fail_path) begin
            ctx_next.live = 1'b0; ctx_next.path_id = '0;
            ctx_next.stable_since = 64'd0;
            ctx_next.fails = fails_inc;
            go = 1'b1;
            if (fails_inc >= cfg.max_retries) begin
                ctx_next.due = 64'd0; target = ST_CLOSED_REC;
            end else begin
                ctx_next.due = item.now + {32'd0, delay}; target = fail_tgt;
            end
        end

        if (free_chk && ctx.state == ST_CLOSED_DROP && !sock_n && !live_n &&
            pid_n == '0) begin
            go = 1'b1; target = ST_CLOSED_FREE;
        end

        // A real transition needs a new state or an unanchored entry time.
        changed = go && (target != ctx.state || ctx.entered == 64'd0);
        peer = PEER_NONE;
        if (changed) begin
            ctx_next.state   = target;
            ctx_next.entered = item.now;
            if (ctx.state == ST_ACTIVE && target == ST_STANDBY) peer = PEER_STANDBY;
            else if (ctx.state == ST_STANDBY && target == ST_ACTIVE) peer = PEER_AVAILABLE;
            else if ((ctx.state == ST_ACTIVE || ctx.state == ST_STANDBY) &&
                     target == ST_DEGRADED) peer = PEER_FROZEN;
        end

        since = item.now - ctx_next.entered;
        warn  = 1'b0;
        if (ctx_next.entered != 64'd0) begin
            if (public_of(ctx_next.state) == PUB_PENDING) begin
                warn = since > {32'd0, cfg.pend_warn};
            end else if (public_of(ctx_next.state) == PUB_DEGRADED) begin
                warn = ctx_next.due != 64'd0 &&
                       item.now > ctx_next.due + {32'd0, cfg.deg_grace} &&
                       since > {32'd0, cfg.deg_grace};
            end
        end

        res.lstate     = ctx_next.state;
        res.pub        = public_of(ctx_next.state);
        res.changed    = changed;
        res.reason     = changed ? why : (budget ? WHY_BUDGET : WHY_ATTACH);
        res.raise      = (ctx_next.state != ctx.state) && (item.opcode != OP_ATTACH);
        res.peer       = peer;
        res.unexpected = unexp;
        res.retries    = ctx_next.fails;
        res.deadline   = ctx_next.due;
        res.warn       = warn;
        res.budget     = budget;
    end

endmodule

@@ rtl/path_lifecycle_fsm.sv @@
// ----------------------------------------------------------------------------
// path_lifecycle_fsm
// Lifecycle controller for one multipath link, one event per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one event per transaction; m_axis returns one result per
//   event in the same order. The configuration port is a write-only register
//   file (index 0..5); the user must write it only while no event is in
//   flight, as the block itself does not enforce this. An accepted event is
//   registered, decoded by one pass of combinational logic, and the result
//   is captured in the output register as the event advances. Throughput is
//   one event per cycle while the receiver does not stall; the input register
//   advances whenever the output register is empty or being drained.
//   When the receiver stalls, the result holds in the output register and
//   the input register holds its event; s_axis_tready drops once both are
//   full. Reset clears the context to closed free with all counters and
//   times zero and loads the register defaults.
// ----------------------------------------------------------------------------
module path_lifecycle_fsm (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic [2:0]               cfg_addr,
    input  logic [31:0]              cfg_wdata,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // opcode[3:0], attempt_result[5:4], new_path_id[67:6], now_us[131:68],
    // validated_to_standby[132], zero fill
    input  logic [plf_pkg::IN_W-1:0] s_axis_tdata,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // lifecycle_state[3:0], public_status[6:4], state_changed[7],
    // transition_reason[11:8], raise_path_event[12], peer_status[14:13],
    // unexpected_event[15], retry_count[23:16], retry_deadline[87:24],
    // residence_warn[88], budget_reset[89], zero fill
    output logic [plf_pkg::OUT_W-1:0] m_axis_tdata
);
    import plf_pkg::*;

    cfg_t    cfg;
    item_t   item_reg;
    logic    in_valid_reg;
    ctx_t    ctx_reg, ctx_next;
    result_t res_next, res_reg;
    logic    out_valid_reg;
    logic    advance;

    plf_cfg_regs u_cfg (
        .aclk (aclk), .aresetn (aresetn), .cfg_we (cfg_we),
        .cfg_addr (cfg_addr), .cfg_wdata (cfg_wdata), .cfg (cfg)
    );

    plf_next_state u_next (
        .cfg (cfg), .item (item_reg), .ctx (ctx_reg),
        .ctx_next (ctx_next), .res (res_next)
    );

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ctx_reg       <= '{ST_CLOSED_FREE, 1'b0, 1'b0, 1'b0, 62'd0, 8'd0,
                               64'd0, 64'd0, 64'd0};
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                ctx_reg       <= ctx_next;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            item_reg.opcode     <= s_axis_tdata[3:0];
            item_reg.res        <= s_axis_tdata[5:4];
            item_reg.path_id    <= s_axis_tdata[67:6];
            item_reg.now        <= s_axis_tdata[131:68];
            item_reg.to_standby <= s_axis_tdata[132];
        end
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_W-90){1'b0}}, res_reg.budget, res_reg.warn,
                            res_reg.deadline, res_reg.retries, res_reg.unexpected,
                            res_reg.peer, res_reg.raise, res_reg.reason,
                            res_reg.changed, res_reg.pub, res_reg.lstate};

endmodule

@@ rtl/plf_checker.sv @@
// ----------------------------------------------------------------------------
// plf_checker
// Port-level checks on the lifecycle controller, bound to the top level.
// ----------------------------------------------------------------------------
`include "path_lifecycle_fsm_assert.svh"

module plf_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [95:0] m_axis_tdata
);
    import plf_pkg::*;

    // Held result stays put while the receiver stalls
    `PLF_ASSERT_NEXT(a_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result dropped under stall")
    // Public status reads active exactly when the lifecycle state is active
    `PLF_ASSERT_IMPL(a_pub, aclk, aresetn, !m_axis_tvalid || (m_axis_tdata[3:0] == ST_ACTIVE) == (m_axis_tdata[6:4] == PUB_ACTIVE), "public status mismatch")
    // A budget reset never coincides with a real transition
    `PLF_ASSERT_IMPL(a_budget, aclk, aresetn, !m_axis_tvalid || !(m_axis_tdata[89] && m_axis_tdata[7]), "budget reset with transition")
    // A peer notice only comes with a real transition
    `PLF_ASSERT_IMPL(a_peer, aclk, aresetn, !m_axis_tvalid || m_axis_tdata[14:13] == PEER_NONE || m_axis_tdata[7], "peer notice without transition")
    // Input blocks only behind a stalled result
    `PLF_ASSERT_IMPL(a_block, aclk, aresetn, s_axis_tready || (m_axis_tvalid && !m_axis_tready), "input blocked without stall")
endmodule

bind path_lifecycle_fsm plf_checker u_plf_checker (
    .aclk (aclk), .aresetn (aresetn), .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid), .m_axis_tready (m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
);
